/* rtl/v3n_pkg.sv */
// ----------------------------------------------------------------------------
// v3n_pkg
// Word types and small helpers shared by the vector normalize pipeline.
// ----------------------------------------------------------------------------
package v3n_pkg;

	// Input word: one vector, signed fixed point components
	typedef struct packed {
		logic signed [31:0] in_x;
		logic signed [31:0] in_y;
		logic signed [31:0] in_z;
	} vec_t;

	// Result word: unit vector (or input), length and pass-through flag
	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic        [31:0] length;
		logic               passed_through;
	} res_t;

	localparam logic [15:0] MIN_LENGTH_RST = 16'd1;
	localparam int          SQRT_STEPS     = 32;

	// Magnitude of a two's complement component (0x80000000 maps to 2^31)
	function automatic logic [31:0] mag32(input logic [31:0] a);
		return a[31] ? (~a + 32'd1) : a;
	endfunction

endpackage

/* rtl/vector3_normalize.sv */
// ----------------------------------------------------------------------------
// vector3_normalize
// Normalizes a 3D signed fixed point vector to unit length.
// ----------------------------------------------------------------------------
// Usage:
//   vec channel (vec_valid / vec_stall / vec) takes one vector word per cycle while vec_stall is low.
//   res channel (res_valid / res_stall / res) gives one result word per
//   vector: unit vector, floored length and a pass-through flag.
//   cfg channel (cfg_valid / cfg_ready / cfg_data) writes min_length; it is
//   always ready and should be written only while the pipeline is empty.
// Stages: 3 for the sum of squares, 32 root stages (one root bit each),
//   one entry stage, FRAC_BITS+1 divider stages (one quotient bit each),
//   one output register.
// Throughput: one vector per cycle while no held result stalls the pipeline,
//   given by the fully pipelined root and dividers.
// Reset: all valid bits clear, min_length returns to 1.
// Stall: res_stall with a result waiting freezes the whole pipeline and
//   raises vec_stall in the same cycle; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module vector3_normalize import v3n_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        vec_valid,
	output logic        vec_stall,
	input  vec_t        vec,
	output logic        res_valid,
	input  logic        res_stall,
	output res_t        res
);

	logic        en;
	logic [15:0] min_length_q;
	logic        sq_valid, rt_valid;
	vec_t        sq_vec, rt_vec;
	logic [63:0] sq_sum;
	logic [31:0] rt_len;

	// pipeline advances unless a finished word is held
	assign en        = !(res_valid && res_stall);
	assign vec_stall = !en;
	assign cfg_ready = 1'b1;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q <= MIN_LENGTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			min_length_q <= cfg_data;
		end
	end

	v3n_sumsq u_sumsq (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vec_valid),
		.in_vec    (vec),
		.out_valid (sq_valid),
		.out_vec   (sq_vec),
		.out_sum   (sq_sum)
	);

	v3n_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.in_vec    (sq_vec),
		.in_sum    (sq_sum),
		.out_valid (rt_valid),
		.out_vec   (rt_vec),
		.out_root  (rt_len)
	);

	v3n_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.min_length (min_length_q),
		.in_valid   (rt_valid),
		.in_vec     (rt_vec),
		.in_len     (rt_len),
		.out_valid  (res_valid),
		.out_res    (res)
	);

`ifndef SYNTHESIS
	localparam logic signed [31:0] UNIT = 32'sd1 <<< FRAC_BITS;

	// a normalized word always had a nonzero length at or above threshold
	a_norm_len: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.passed_through) |->
		(res.length != 32'd0) && (res.length >= {16'd0, min_length_q}))
		else $error("normalized result with length below threshold");

	// normalized components never exceed one in magnitude
	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.passed_through) |->
		(res.out_x <= UNIT) && (res.out_x >= -UNIT) &&
		(res.out_y <= UNIT) && (res.out_y >= -UNIT) &&
		(res.out_z <= UNIT) && (res.out_z >= -UNIT))
		else $error("normalized component out of range");

	// a held result word is still valid in the next cycle
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> res_valid)
		else $error("held result word lost");
`endif

endmodule

/* rtl/v3n_sumsq.sv */
// ----------------------------------------------------------------------------
// v3n_sumsq
// Three stage front end: component magnitudes, squares, sum of squares.
// ----------------------------------------------------------------------------
module v3n_sumsq import v3n_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  vec_t        in_vec,
	output logic        out_valid,
	output vec_t        out_vec,
	output logic [63:0] out_sum
);

	logic        vld_s1, vld_s2, vld_s3;
	vec_t        vec_s1, vec_s2, vec_s3;
	logic [31:0] mx_s1, my_s1, mz_s1;
	logic [63:0] sx_s2, sy_s2, sz_s2;
	logic [63:0] sum_s3;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// payload: magnitude, square, sum
	always_ff @(posedge clk) begin
		if (en) begin
			vec_s1 <= in_vec;
			mx_s1  <= mag32(in_vec.in_x);
			my_s1  <= mag32(in_vec.in_y);
			mz_s1  <= mag32(in_vec.in_z);
			vec_s2 <= vec_s1;
			sx_s2  <= {32'd0, mx_s1} * {32'd0, mx_s1};
			sy_s2  <= {32'd0, my_s1} * {32'd0, my_s1};
			sz_s2  <= {32'd0, mz_s1} * {32'd0, mz_s1};
			vec_s3 <= vec_s2;
			// each square is at most 2^62, so the sum fits in 64 bits
			sum_s3 <= sx_s2 + sy_s2 + sz_s2;
		end
	end

	assign out_valid = vld_s3;
	assign out_vec   = vec_s3;
	assign out_sum   = sum_s3;

endmodule

/* rtl/v3n_sqrt.sv */
// ----------------------------------------------------------------------------
// v3n_sqrt
// Pipelined floored integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module v3n_sqrt import v3n_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  vec_t        in_vec,
	input  logic [63:0] in_sum,
	output logic        out_valid,
	output vec_t        out_vec,
	output logic [31:0] out_root
);

	logic        vld_s  [0:SQRT_STEPS];
	vec_t        vec_s  [0:SQRT_STEPS];
	logic [63:0] n_s    [0:SQRT_STEPS];
	logic [33:0] rem_s  [0:SQRT_STEPS];
	logic [31:0] root_s [0:SQRT_STEPS];

	assign vld_s[0]  = in_valid;
	assign vec_s[0]  = in_vec;
	assign n_s[0]    = in_sum;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		logic [35:0] cur;
		logic [35:0] trial;
		logic        take;

		// bring down two bits, try root*4+1
		assign cur   = {rem_s[k], n_s[k][63:62]};
		assign trial = {2'b00, root_s[k], 2'b01};
		assign take  = (cur >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				vec_s[k+1]  <= vec_s[k];
				n_s[k+1]    <= {n_s[k][61:0], 2'b00};
				rem_s[k+1]  <= take ? 34'(cur - trial) : cur[33:0];
				root_s[k+1] <= {root_s[k][30:0], take};
			end
		end
	end

	assign out_valid = vld_s[SQRT_STEPS];
	assign out_vec   = vec_s[SQRT_STEPS];
	assign out_root  = root_s[SQRT_STEPS];

endmodule

/* rtl/v3n_div.sv */
// ----------------------------------------------------------------------------
// v3n_div
// Threshold test and three pipelined restoring dividers, one quotient bit
// per stage, followed by sign fix-up and the result register.
// ----------------------------------------------------------------------------
module v3n_div import v3n_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic [15:0] min_length,
	input  logic        in_valid,
	input  vec_t        in_vec,
	input  logic [31:0] in_len,
	output logic        out_valid,
	output res_t        out_res
);

	// quotient magnitude is at most 2^FRAC_BITS
	localparam int QW = FRAC_BITS + 1;
	localparam int DW = 32 + FRAC_BITS;

	logic          vld_s  [0:QW];
	vec_t          vec_s  [0:QW];
	logic [31:0]   len_s  [0:QW];
	logic          pass_s [0:QW];
	logic [2:0]    neg_s  [0:QW];
	logic [31:0]   rem_s  [0:QW][0:2];
	logic [QW-1:0] lo_s   [0:QW][0:2];
	logic [QW-1:0] quo_s  [0:QW][0:2];

	logic [31:0]   comp [0:2];
	logic          vld_q;
	res_t          res_q;

	assign comp[0] = in_vec.in_x;
	assign comp[1] = in_vec.in_y;
	assign comp[2] = in_vec.in_z;

	// entry stage: threshold compare, magnitudes, split dividends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s[0]  <= in_vec;
			len_s[0]  <= in_len;
			// zero length always passes, so the divider never sees zero
			pass_s[0] <= (in_len == 32'd0) || (in_len < {16'd0, min_length});
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_entry
		logic [DW-1:0] dvd;
		assign dvd = {mag32(comp[i]), {FRAC_BITS{1'b0}}};

		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[0][i]    <= comp[i][31];
				rem_s[0][i]    <= 32'(dvd[DW-1:QW]);
				lo_s[0][i]     <= dvd[QW-1:0];
				quo_s[0][i]    <= '0;
			end
		end
	end

	// one quotient bit per stage in each lane
	for (genvar k = 0; k < QW; k++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				vec_s[k+1]  <= vec_s[k];
				len_s[k+1]  <= len_s[k];
				pass_s[k+1] <= pass_s[k];
				neg_s[k+1]  <= neg_s[k];
			end
		end

		for (genvar i = 0; i < 3; i++) begin : g_lane
			logic [32:0] cur;
			logic        take;

			// remainder stays below the divisor, so 32 bits hold it
			assign cur  = {rem_s[k][i], lo_s[k][i][QW-1]};
			assign take = (cur >= {1'b0, len_s[k]});

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1][i] <= take ? 32'(cur - {1'b0, len_s[k]}) : cur[31:0];
					lo_s[k+1][i]  <= lo_s[k][i] << 1;
					quo_s[k+1][i] <= {quo_s[k][i][QW-2:0], take};
				end
			end
		end
	end

	// sign fix-up and pass-through select
	logic [31:0] qs [0:2];
	logic [31:0] raw [0:2];

	assign raw[0] = vec_s[QW].in_x;
	assign raw[1] = vec_s[QW].in_y;
	assign raw[2] = vec_s[QW].in_z;

	for (genvar i = 0; i < 3; i++) begin : g_sign
		logic [31:0] qz;
		assign qz    = 32'(quo_s[QW][i]);
		assign qs[i] = pass_s[QW] ? raw[i] : (neg_s[QW][i] ? (~qz + 32'd1) : qz);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q.out_x          <= qs[0];
			res_q.out_y          <= qs[1];
			res_q.out_z          <= qs[2];
			res_q.length         <= len_s[QW];
			res_q.passed_through <= pass_s[QW];
		end
	end

	assign out_valid = vld_q;
	assign out_res   = res_q;

endmodule

/* sim/vector3_normalize_checker.sv */
// ----------------------------------------------------------------------------
// vector3_normalize_checker
// Watches the vector, result and config channels of the normalize pipeline,
// computes the expected unit vector for every accepted vector and compares
// each result word field by field in order.
// ----------------------------------------------------------------------------
module vector3_normalize_checker import v3n_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        vec_valid,
	input  logic        vec_stall,
	input  vec_t        vec,
	input  logic        res_valid,
	input  logic        res_stall,
	input  res_t        res,
	output int          fail_count,
	output int          pending
);

	logic [15:0] thresh;
	res_t        expected_q[$];

	// Bit-serial floored square root of a 64-bit value
	function automatic logic [63:0] floor_root(input logic [63:0] n);
		logic [63:0] acc;
		logic [63:0] bitv;
		acc  = '0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= acc + bitv) begin
				n   = n - (acc + bitv);
				acc = (acc >> 1) + bitv;
			end else begin
				acc = acc >> 1;
			end
			bitv = bitv >> 2;
		end
		return acc;
	endfunction

	// Expected result word for one vector under the current threshold
	function automatic res_t unit_vector(input vec_t v, input logic [15:0] th);
		logic [31:0] comp[3];
		logic [63:0] m[3];
		logic [63:0] sum;
		logic [63:0] len;
		logic [63:0] q;
		logic [31:0] o[3];
		res_t        r;
		comp[0] = v.in_x;
		comp[1] = v.in_y;
		comp[2] = v.in_z;
		sum = '0;
		for (int i = 0; i < 3; i++) begin
			m[i] = comp[i][31] ? (64'h1_0000_0000 - {32'd0, comp[i]}) : {32'd0, comp[i]};
			sum = sum + m[i] * m[i];
		end
		len = floor_root(sum);
		// zero length always passes through, even with a zero threshold
		r.passed_through = (len == 0) || (len < {48'd0, th});
		for (int i = 0; i < 3; i++) begin
			if (r.passed_through) begin
				o[i] = comp[i];
			end else begin
				q = (m[i] << FRAC_BITS) / len;
				o[i] = comp[i][31] ? (32'd0 - q[31:0]) : q[31:0];
			end
		end
		r.out_x  = o[0];
		r.out_y  = o[1];
		r.out_z  = o[2];
		r.length = len[31:0];
		return r;
	endfunction

	assign pending = expected_q.size();

	// Track config, queue expectations, compare results
	always @(posedge clk or negedge arst_n) begin
		res_t exp_w;
		if (!arst_n) begin
			thresh     <= MIN_LENGTH_RST;
			fail_count <= 0;
			expected_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) thresh <= cfg_data;
			if (vec_valid && !vec_stall) expected_q.push_back(unit_vector(vec, thresh));
			if (res_valid && !res_stall) begin
				if (expected_q.size() == 0) begin
					if (fail_count < 10) $display("unexpected result word %h", res);
					fail_count <= fail_count + 1;
				end else begin
					exp_w = expected_q.pop_front();
					if (exp_w !== res) begin
						if (fail_count < 10)
							$display("mismatch: exp x=%h y=%h z=%h len=%h pt=%b got x=%h y=%h z=%h len=%h pt=%b",
								exp_w.out_x, exp_w.out_y, exp_w.out_z, exp_w.length,
								exp_w.passed_through, res.out_x, res.out_y, res.out_z,
								res.length, res.passed_through);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

/* sim/tb_vector3_normalize.sv */
// ----------------------------------------------------------------------------
// tb_vector3_normalize
// Drives directed and random vectors through the normalize pipeline under
// several idle/stall mixes and threshold settings; the checker does the
// scoring and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_vector3_normalize;
	import v3n_pkg::*;

	localparam int LATENCY = 54;
	localparam int LIMIT   = 400000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;
	logic        vec_valid = 0;
	logic        vec_stall;
	vec_t        vec = '0;
	logic        res_valid;
	logic        res_stall = 0;
	res_t        res;
	int          fail_count;
	int          pending;
	int          cycles = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;

	always #5 clk = ~clk;

	vector3_normalize u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.vec_valid(vec_valid), .vec_stall(vec_stall), .vec(vec),
		.res_valid(res_valid), .res_stall(res_stall), .res(res)
	);

	vector3_normalize_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.vec_valid(vec_valid), .vec_stall(vec_stall), .vec(vec),
		.res_valid(res_valid), .res_stall(res_stall), .res(res),
		.fail_count(fail_count), .pending(pending)
	);

	// Timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb_vector3_normalize: errors");
			$finish;
		end
	end

	// Receiver stall
	always @(posedge clk) begin
		res_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Random component: mix of full range, small magnitudes and extremes
	function automatic logic [31:0] rand_comp();
		case ($urandom_range(5))
			0: return $urandom_range(1, 0) ? 32'h8000_0000 : 32'h7fff_ffff;
			1: return $signed($urandom_range(511)) - 256;
			2: return $signed($urandom_range(32'h3ffff)) - 32'h20000;
			default: return $urandom;
		endcase
	endfunction

	// Send one vector word, with random idle cycles before it
	task automatic send_vec(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
		while ($urandom_range(99) < send_idle_pct) begin
			vec_valid <= 1'b0;
			@(posedge clk);
		end
		vec_valid <= 1'b1;
		vec <= '{x, y, z};
		@(posedge clk);
		while (vec_stall) @(posedge clk);
	endtask

	// Wait for the pipeline to empty, then write the threshold
	task automatic set_thresh(input logic [15:0] th);
		vec_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= th;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [15:0] settings[6];
		settings = '{16'd0, 16'hffff, 16'd1, 16'h0100, 16'h8000, 16'h0010};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, zero vector, tiny lengths under the reset threshold, then zero and 0xffff thresholds
		send_vec(0, 0, 0);
		send_vec(1, 0, 0);
		send_vec(32'hffff_ffff, 0, 0);
		send_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_vec(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		send_vec(32'h8000_0000, 0, 0);
		send_vec(0, 32'h7fff_ffff, 0);
		send_vec(0, 0, 32'h0001_0000);
		send_vec(32'h0001_0000, 32'hffff_0000, 32'h0001_0000);
		send_vec(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f);
		send_vec(2, 2, 1);
		set_thresh(16'd0);
		send_vec(0, 0, 0);
		send_vec(1, 0, 0);
		set_thresh(16'hffff);
		send_vec(32'h0000_fffe, 0, 0);
		send_vec(32'h0000_ffff, 0, 0);
		send_vec(32'h0001_0000, 0, 0);
		send_vec(32'hffff_0000, 32'h0000_ffff, 0);

		// Random phases: threshold setting crossed with idle/stall mixes
		for (int p = 0; p < 6; p++) begin
			set_thresh(settings[p]);
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
				default: begin send_idle_pct = 9; recv_stall_pct = 9; end
			endcase
			for (int i = 0; i < 240; i++) send_vec(rand_comp(), rand_comp(), rand_comp());
		end

		vec_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb_vector3_normalize: clean");
		end else begin
			$display("tb_vector3_normalize: errors");
		end
		$finish;
	end

endmodule

/* vector3_normalize.f */
rtl/v3n_pkg.sv
rtl/v3n_sumsq.sv
rtl/v3n_sqrt.sv
rtl/v3n_div.sv
rtl/vector3_normalize.sv
sim/vector3_normalize_checker.sv
sim/tb_vector3_normalize.sv
